// File: rtl/bmi_pkg.sv
// Package for the ball motion integrate block: widths, register indexes,
// configuration and stage types, shared saturation and per-axis helpers.
// No dependencies.
`default_nettype none
package bmi_pkg;

    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        REG_PUSH_GAIN    = 3'd0,
        REG_MOVE_GAIN    = 3'd1,
        REG_GRAVITY_STEP = 3'd2,
        REG_BOUNCE_GAIN  = 3'd3,
        REG_WALL_BOUNCE  = 3'd4,
        REG_VIEW_W       = 3'd5,
        REG_VIEW_H       = 3'd6
    } cfg_idx_e;

    localparam logic [31:0] PUSH_GAIN_RST   = 32'(1) << FRAC_BITS;
    localparam logic [31:0] MOVE_GAIN_RST   = 32'(1) << FRAC_BITS;
    localparam logic [16:0] BOUNCE_GAIN_RST = 17'(1) << (FRAC_BITS - 1);
    localparam logic [14:0] VIEW_W_RST      = 15'd1024;
    localparam logic [14:0] VIEW_H_RST      = 15'd768;

    // Product widths after the fraction bits are dropped
    localparam int MH_W  = 65 - FRAC_BITS;  // signed 32 x unsigned 32
    localparam int LIM_W = 63 - FRAC_BITS;  // unsigned 31 x unsigned 32
    localparam int B1_W  = 49 - FRAC_BITS;  // unsigned 32 x unsigned 17
    localparam int B2_W  = 50 - FRAC_BITS;  // B1_W+... x unsigned 17
    // Working width for velocity sums and positions before saturation
    localparam int ACC_W = MH_W + 4;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7fff_ffff);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(32'sh8000_0000);

    typedef struct packed {
        logic [31:0]        push_gain;
        logic [31:0]        move_gain;
        logic signed [31:0] gravity_step;
        logic [16:0]        bounce_gain;
        logic               wall_bounce;
        logic [14:0]        view_w;
        logic [14:0]        view_h;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
        logic [30:0]        ball_radius;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        radius;
    } vel_res_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] pos;
        logic                    lo_hit;
        logic                    hi_hit;
        logic                    oob;
    } axis_fix_t;

    typedef struct packed {
        axis_fix_t          fx;
        axis_fix_t          fy;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } move_res_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               out_of_bounds;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > SAT_MAX)
            return SAT_MAX[31:0];
        else if (v < SAT_MIN)
            return SAT_MIN[31:0];
        else
            return v[31:0];
    endfunction

    // Add push and gravity, clamp to the radius limit, saturate
    function automatic logic signed [31:0] vel_axis(
        input logic signed [31:0]     v,
        input logic signed [MH_W-1:0] mh,
        input logic signed [31:0]     add,
        input logic [LIM_W-1:0]       lim
    );
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] l;
        s = ACC_W'(v) + ACC_W'(mh) + ACC_W'(add);
        l = ACC_W'(lim);
        if (s > l)
            s = l;
        else if (s < -l)
            s = -l;
        return sat32(s);
    endfunction

    // Advance one axis and resolve the low edge, then the high edge; with edges off, flag out of bounds
    function automatic axis_fix_t fix_axis(
        input logic signed [31:0]     pos,
        input logic signed [MH_W-1:0] mv,
        input logic [30:0]            r,
        input logic [14:0]            span,
        input logic                   solid
    );
        axis_fix_t               f;
        logic signed [ACC_W-1:0] p;
        logic signed [ACC_W-1:0] rr;
        logic signed [ACC_W-1:0] lim;
        logic signed [ACC_W-1:0] p1;
        p   = ACC_W'(pos) + ACC_W'(mv);
        rr  = ACC_W'(r);
        lim = ACC_W'(span) << FRAC_BITS;
        f.lo_hit = solid && ((p - rr) < 0);
        p1       = f.lo_hit ? rr : p;
        f.hi_hit = solid && ((p1 + rr) > lim);
        f.pos    = f.hi_hit ? (lim - rr) : p1;
        f.oob    = !solid && (((p + rr) < 0) || ((p - rr) > lim));
        return f;
    endfunction

    // Pick the velocity after zero, one or two reflections
    function automatic logic signed [31:0] bounce_v(
        input logic signed [31:0] v,
        input logic [B1_W-1:0]    b1,
        input logic [B2_W-1:0]    b2,
        input logic               lo,
        input logic               hi
    );
        logic signed [ACC_W-1:0] r;
        if (lo && hi)
            r = -$signed(ACC_W'(b2));
        else if (lo)
            r = $signed(ACC_W'(b1));
        else if (hi)
            r = -$signed(ACC_W'(b1));
        else
            r = ACC_W'(v);
        return sat32(r);
    endfunction

endpackage
`default_nettype wire

// File: rtl/bmi_if.sv
// Channel interfaces of the ball motion integrate block: ball input,
// result output and configuration write. No dependencies.
`default_nettype none
interface bmi_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic [30:0]        ball_radius;
    modport source (output valid, pos_x, pos_y, vel_x, vel_y, push_x, push_y,
                    ball_radius, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, push_x, push_y,
                    ball_radius, output ready);
endinterface

interface bmi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               out_of_bounds;
    modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    out_of_bounds, input ready);
    modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    out_of_bounds, output ready);
endinterface

interface bmi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/bmi_vel_stage.sv
// Velocity stages: push and radius-limit products, then add, clamp and
// saturate. Depends on bmi_pkg.
`default_nettype none
module bmi_vel_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire bmi_pkg::item_t    in_item,
    input  wire bmi_pkg::cfg_t     cfg,
    output logic                   out_valid,
    output bmi_pkg::vel_res_t      out_res
);
    typedef struct packed {
        logic signed [31:0]                 pos_x;
        logic signed [31:0]                 pos_y;
        logic signed [31:0]                 vel_x;
        logic signed [31:0]                 vel_y;
        logic signed [bmi_pkg::MH_W-1:0]    mh_x;
        logic signed [bmi_pkg::MH_W-1:0]    mh_y;
        logic [bmi_pkg::LIM_W-1:0]          lim;
        logic [30:0]                        radius;
    } s1_t;

    s1_t                 s1_reg, s1_next;
    logic                v1_reg;
    logic                v2_reg;
    bmi_pkg::vel_res_t   s2_reg, s2_next;
    logic signed [64:0]  prod_x, prod_y;
    logic [62:0]         prod_l;

    always_comb
    begin
        prod_x = 65'(in_item.push_x) * $signed({1'b0, cfg.push_gain});
        prod_y = 65'(in_item.push_y) * $signed({1'b0, cfg.push_gain});
        prod_l = 63'(in_item.ball_radius) * 63'(cfg.push_gain);
        s1_next.pos_x  = in_item.pos_x;
        s1_next.pos_y  = in_item.pos_y;
        s1_next.vel_x  = in_item.vel_x;
        s1_next.vel_y  = in_item.vel_y;
        s1_next.mh_x   = prod_x[64:bmi_pkg::FRAC_BITS];
        s1_next.mh_y   = prod_y[64:bmi_pkg::FRAC_BITS];
        s1_next.lim    = prod_l[62:bmi_pkg::FRAC_BITS];
        s1_next.radius = in_item.ball_radius;
    end

    always_comb
    begin
        s2_next.pos_x  = s1_reg.pos_x;
        s2_next.pos_y  = s1_reg.pos_y;
        s2_next.vel_x  = bmi_pkg::vel_axis(s1_reg.vel_x, s1_reg.mh_x, 32'sd0, s1_reg.lim);
        s2_next.vel_y  = bmi_pkg::vel_axis(s1_reg.vel_y, s1_reg.mh_y, cfg.gravity_step,
                                           s1_reg.lim);
        s2_next.radius = s1_reg.radius;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_res   = s2_reg;
endmodule
`default_nettype wire

// File: rtl/bmi_move_stage.sv
// Position stages: velocity times move gain, then advance and edge
// resolution per axis. Depends on bmi_pkg.
`default_nettype none
module bmi_move_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire bmi_pkg::vel_res_t  in_res,
    input  wire bmi_pkg::cfg_t      cfg,
    output logic                    out_valid,
    output bmi_pkg::move_res_t      out_res
);
    typedef struct packed {
        bmi_pkg::vel_res_t               v;
        logic signed [bmi_pkg::MH_W-1:0] mv_x;
        logic signed [bmi_pkg::MH_W-1:0] mv_y;
    } s3_t;

    s3_t                 s3_reg, s3_next;
    bmi_pkg::move_res_t  s4_reg, s4_next;
    logic                v3_reg;
    logic                v4_reg;
    logic signed [64:0]  prod_x, prod_y;

    always_comb
    begin
        prod_x = 65'(in_res.vel_x) * $signed({1'b0, cfg.move_gain});
        prod_y = 65'(in_res.vel_y) * $signed({1'b0, cfg.move_gain});
        s3_next.v    = in_res;
        s3_next.mv_x = prod_x[64:bmi_pkg::FRAC_BITS];
        s3_next.mv_y = prod_y[64:bmi_pkg::FRAC_BITS];
    end

    always_comb
    begin
        s4_next.fx = bmi_pkg::fix_axis(s3_reg.v.pos_x, s3_reg.mv_x, s3_reg.v.radius,
                                       cfg.view_w, cfg.wall_bounce);
        s4_next.fy = bmi_pkg::fix_axis(s3_reg.v.pos_y, s3_reg.mv_y, s3_reg.v.radius,
                                       cfg.view_h, cfg.wall_bounce);
        s4_next.vel_x = s3_reg.v.vel_x;
        s4_next.vel_y = s3_reg.v.vel_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = s4_reg;
endmodule
`default_nettype wire

// File: rtl/bmi_bounce_stage.sv
// Bounce stages: reflected speed times bounce gain, a second product for a
// double hit, then final saturation into the result register. Depends on bmi_pkg.
`default_nettype none
module bmi_bounce_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire bmi_pkg::move_res_t in_res,
    input  wire bmi_pkg::cfg_t      cfg,
    output logic                    out_valid,
    output bmi_pkg::result_t        out_res
);
    typedef struct packed {
        bmi_pkg::move_res_t        m;
        logic [bmi_pkg::B1_W-1:0]  b1_x;
        logic [bmi_pkg::B1_W-1:0]  b1_y;
    } s5_t;

    s5_t                 s5_reg, s5_next;
    bmi_pkg::result_t    s6_reg, s6_next;
    logic                v5_reg;
    logic                v6_reg;
    logic [31:0]         abs_x, abs_y;
    logic [48:0]         p1_x, p1_y;
    logic [49:0]         p2_x, p2_y;

    always_comb
    begin
        abs_x = in_res.vel_x[31] ? 32'(-in_res.vel_x) : 32'(in_res.vel_x);
        abs_y = in_res.vel_y[31] ? 32'(-in_res.vel_y) : 32'(in_res.vel_y);
        p1_x  = 49'(abs_x) * 49'(cfg.bounce_gain);
        p1_y  = 49'(abs_y) * 49'(cfg.bounce_gain);
        s5_next.m    = in_res;
        s5_next.b1_x = p1_x[48:bmi_pkg::FRAC_BITS];
        s5_next.b1_y = p1_y[48:bmi_pkg::FRAC_BITS];
    end

    always_comb
    begin
        p2_x = 50'(s5_reg.b1_x) * 50'(cfg.bounce_gain);
        p2_y = 50'(s5_reg.b1_y) * 50'(cfg.bounce_gain);
        s6_next.new_pos_x = bmi_pkg::sat32(s5_reg.m.fx.pos);
        s6_next.new_pos_y = bmi_pkg::sat32(s5_reg.m.fy.pos);
        s6_next.new_vel_x = bmi_pkg::bounce_v(s5_reg.m.vel_x, s5_reg.b1_x,
                                              p2_x[49:bmi_pkg::FRAC_BITS],
                                              s5_reg.m.fx.lo_hit, s5_reg.m.fx.hi_hit);
        s6_next.new_vel_y = bmi_pkg::bounce_v(s5_reg.m.vel_y, s5_reg.b1_y,
                                              p2_y[49:bmi_pkg::FRAC_BITS],
                                              s5_reg.m.fy.lo_hit, s5_reg.m.fy.hi_hit);
        s6_next.out_of_bounds = s5_reg.m.fx.oob || s5_reg.m.fy.oob;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= in_valid;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_res   = s6_reg;
endmodule
`default_nettype wire

// File: rtl/ball_motion_integrate_unit.sv
// Top level of the ball motion integrate block: configuration registers and
// the six-stage pipeline. Depends on bmi_pkg, bmi_if and the bmi_*_stage modules.
//
// Usage:
//   in_ch  - one ball per transaction: position, velocity and collision push
//            in Q16.16, radius in unsigned Q15.16. A transaction completes
//            when valid and ready are both high at a rising edge of clk.
//   out_ch - one result transaction per ball, in input order: new position,
//            new velocity and the out-of-bounds flag.
//   cfg    - register writes (index 0..6 as listed in bmi_pkg::cfg_idx_e);
//            always ready, unknown indexes are dropped. Write only while the
//            pipeline is empty.
//   Throughput is one ball per cycle while the receiver does not stall;
//   the six register stages (push products, velocity clamp, move
//   product, edge resolution, two bounce products) advance together.
//   The last stage is the output register. When the receiver stalls, every
//   stage holds and in_ch.ready drops; nothing is lost or repeated.
//   Reset clears all stage valid bits and loads the register reset values.
`default_nettype none
module ball_motion_integrate_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bmi_in_if.sink     in_ch,
    bmi_out_if.source  out_ch,
    bmi_cfg_if.sink    cfg
);
    bmi_pkg::cfg_t      cfg_reg;
    bmi_pkg::item_t     item;
    bmi_pkg::vel_res_t  vel_res;
    bmi_pkg::move_res_t move_res;
    bmi_pkg::result_t   result;
    logic               vel_valid;
    logic               move_valid;
    logic               res_valid;
    logic               en;

    // Advance the whole pipeline unless the output register holds an untaken result
    assign en          = !res_valid || out_ch.ready;
    assign in_ch.ready = en;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.push_gain    <= bmi_pkg::PUSH_GAIN_RST;
            cfg_reg.move_gain    <= bmi_pkg::MOVE_GAIN_RST;
            cfg_reg.gravity_step <= '0;
            cfg_reg.bounce_gain  <= bmi_pkg::BOUNCE_GAIN_RST;
            cfg_reg.wall_bounce  <= 1'b1;
            cfg_reg.view_w       <= bmi_pkg::VIEW_W_RST;
            cfg_reg.view_h       <= bmi_pkg::VIEW_H_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bmi_pkg::REG_PUSH_GAIN:    cfg_reg.push_gain    <= cfg.data;
                bmi_pkg::REG_MOVE_GAIN:    cfg_reg.move_gain    <= cfg.data;
                bmi_pkg::REG_GRAVITY_STEP: cfg_reg.gravity_step <= $signed(cfg.data);
                bmi_pkg::REG_BOUNCE_GAIN:  cfg_reg.bounce_gain  <= cfg.data[16:0];
                bmi_pkg::REG_WALL_BOUNCE:  cfg_reg.wall_bounce  <= cfg.data[0];
                bmi_pkg::REG_VIEW_W:       cfg_reg.view_w       <= cfg.data[14:0];
                bmi_pkg::REG_VIEW_H:       cfg_reg.view_h       <= cfg.data[14:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    always_comb
    begin
        item.pos_x       = in_ch.pos_x;
        item.pos_y       = in_ch.pos_y;
        item.vel_x       = in_ch.vel_x;
        item.vel_y       = in_ch.vel_y;
        item.push_x      = in_ch.push_x;
        item.push_y      = in_ch.push_y;
        item.ball_radius = in_ch.ball_radius;
    end

    bmi_vel_stage u_vel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .in_item   (item),
        .cfg       (cfg_reg),
        .out_valid (vel_valid),
        .out_res   (vel_res)
    );

    bmi_move_stage u_move (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vel_valid),
        .in_res    (vel_res),
        .cfg       (cfg_reg),
        .out_valid (move_valid),
        .out_res   (move_res)
    );

    bmi_bounce_stage u_bounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (move_valid),
        .in_res    (move_res),
        .cfg       (cfg_reg),
        .out_valid (res_valid),
        .out_res   (result)
    );

    assign out_ch.valid         = res_valid;
    assign out_ch.new_pos_x     = result.new_pos_x;
    assign out_ch.new_pos_y     = result.new_pos_y;
    assign out_ch.new_vel_x     = result.new_vel_x;
    assign out_ch.new_vel_y     = result.new_vel_y;
    assign out_ch.out_of_bounds = result.out_of_bounds;
endmodule
`default_nettype wire

// File: rtl/bmi_checker.sv
// Port-level checks for ball_motion_integrate_unit and the bind that
// attaches them. Depends on ball_motion_integrate_unit and bmi_if.
`default_nettype none
module bmi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_pos_x,
    input wire logic        cfg_ready
);
    // An empty output register always lets a transaction in
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A stalled output holds the pipeline closed
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input open during output stall");

    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_pos_x)))
        else $error("stalled result changed");

    // Configuration writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");
endmodule

bind ball_motion_integrate_unit bmi_checker u_bmi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pos_x (out_ch.new_pos_x),
    .cfg_ready (cfg.ready)
);
`default_nettype wire

// File: tb/sv/ball_motion_integrate_unit_test.sv
// Self-checking bench for ball_motion_integrate_unit: drives balls, predicts
// each integrated result, compares field by field. Depends on bmi_pkg, bmi_if.
`default_nettype none
module ball_motion_integrate_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_LIMIT = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    bmi_in_if  in_ch();
    bmi_out_if out_ch();
    bmi_cfg_if cfg();

    ball_motion_integrate_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Shadow of the block's registers, updated by write_reg and read by the predictor
    bmi_pkg::cfg_t shadow;

    bmi_pkg::item_t   pending_balls[$];
    bmi_pkg::result_t expected_motion[$];

    int  error_count = 0;
    int  balls_sent = 0;
    int  results_seen = 0;
    int  oob_hits = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;
    bit  sink_hold = 1'b0;
    int  quiet_cycles = 0;

    // Floor of a * g >> FRAC_BITS, wide enough for every caller here
    function automatic logic signed [79:0] scale_floor(input logic signed [79:0] a,
                                                     input logic [31:0] g);
        logic signed [79:0] p;
        p = a * $signed({1'b0, g});
        return p >>> bmi_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [79:0] clip32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            return 80'sd2147483647;
        if (v < -80'sd2147483648)
            return -80'sd2147483648;
        return v;
    endfunction

    function automatic bmi_pkg::result_t integrate_ball(input bmi_pkg::item_t b);
        bmi_pkg::result_t o;
        logic signed [79:0] px, py, vx, vy, r, lim, w, h;
        px  = b.pos_x;
        py  = b.pos_y;
        r   = $signed({1'b0, b.ball_radius});
        lim = scale_floor(r, shadow.push_gain);
        w   = $signed({1'b0, shadow.view_w}) <<< bmi_pkg::FRAC_BITS;
        h   = $signed({1'b0, shadow.view_h}) <<< bmi_pkg::FRAC_BITS;
        vx  = b.vel_x + scale_floor(b.push_x, shadow.push_gain);
        vy  = b.vel_y + scale_floor(b.push_y, shadow.push_gain) + shadow.gravity_step;
        // clamp to the radius limit, then saturate
        if (vx > lim) vx = lim; else if (vx < -lim) vx = -lim;
        if (vy > lim) vy = lim; else if (vy < -lim) vy = -lim;
        vx = clip32(vx);
        vy = clip32(vy);
        px = px + scale_floor(vx, shadow.move_gain);
        py = py + scale_floor(vy, shadow.move_gain);
        o.out_of_bounds = 1'b0;
        if (shadow.wall_bounce)
        begin
            // left, right, top, bottom in order; each sees the previous fix
            if (px - r < 0)
            begin
                px = r;
                vx = scale_floor(vx < 0 ? -vx : vx, 32'(shadow.bounce_gain));
            end
            if (px + r > w)
            begin
                px = w - r;
                vx = -scale_floor(vx < 0 ? -vx : vx, 32'(shadow.bounce_gain));
            end
            if (py - r < 0)
            begin
                py = r;
                vy = scale_floor(vy < 0 ? -vy : vy, 32'(shadow.bounce_gain));
            end
            if (py + r > h)
            begin
                py = h - r;
                vy = -scale_floor(vy < 0 ? -vy : vy, 32'(shadow.bounce_gain));
            end
        end
        else if (px + r < 0 || px - r > w || py + r < 0 || py - r > h)
        begin
            o.out_of_bounds = 1'b1;
        end
        o.new_pos_x = 32'(clip32(px));
        o.new_pos_y = 32'(clip32(py));
        o.new_vel_x = 32'(clip32(vx));
        o.new_vel_y = 32'(clip32(vy));
        return o;
    endfunction

    // Driver: advance to the next pending ball after each transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_balls.size() > 0 &&
                    !(src_idle_on && $urandom_range(99) < 36))
                begin
                    bmi_pkg::item_t b;
                    b = pending_balls.pop_front();
                    expected_motion.push_back(integrate_ball(b));
                    balls_sent++;
                    in_ch.valid       <= 1'b1;
                    in_ch.pos_x       <= b.pos_x;
                    in_ch.pos_y       <= b.pos_y;
                    in_ch.vel_x       <= b.vel_x;
                    in_ch.vel_y       <= b.vel_y;
                    in_ch.push_x      <= b.push_x;
                    in_ch.push_y      <= b.push_y;
                    in_ch.ball_radius <= b.ball_radius;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Predict at enqueue time: config only changes when the pipe is empty,
    // and pending_balls is drained before each write.

    // Receiver: random stalls plus a long hold-off window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !sink_hold && !(sink_idle_on && $urandom_range(99) < 36);
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_motion.size() == 0)
            begin
                $error("result with no ball outstanding");
                error_count++;
            end
            else
            begin
                bmi_pkg::result_t e;
                e = expected_motion.pop_front();
                if (e.out_of_bounds) oob_hits++;
                if (out_ch.new_pos_x !== e.new_pos_x)
                begin
                    $error("new_pos_x exp %0d got %0d", e.new_pos_x, out_ch.new_pos_x);
                    error_count++;
                end
                if (out_ch.new_pos_y !== e.new_pos_y)
                begin
                    $error("new_pos_y exp %0d got %0d", e.new_pos_y, out_ch.new_pos_y);
                    error_count++;
                end
                if (out_ch.new_vel_x !== e.new_vel_x)
                begin
                    $error("new_vel_x exp %0d got %0d", e.new_vel_x, out_ch.new_vel_x);
                    error_count++;
                end
                if (out_ch.new_vel_y !== e.new_vel_y)
                begin
                    $error("new_vel_y exp %0d got %0d", e.new_vel_y, out_ch.new_vel_y);
                    error_count++;
                end
                if (out_ch.out_of_bounds !== e.out_of_bounds)
                begin
                    $error("out_of_bounds exp %0d got %0d", e.out_of_bounds,
                           out_ch.out_of_bounds);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: drop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT)
            begin
                $display("timeout: %0d results pending", expected_motion.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 32'h00ff_ffff);
            3: return -$urandom_range(0, 32'h00ff_ffff);
            default: return $urandom;
        endcase
    endfunction

    // Mostly on-screen balls with modest motion, some wild ones
    function automatic bmi_pkg::item_t rand_ball();
        bmi_pkg::item_t b;
        if ($urandom_range(99) < 75)
        begin
            b.pos_x       = $urandom_range(0, 32'(shadow.view_w) << bmi_pkg::FRAC_BITS);
            b.pos_y       = $urandom_range(0, 32'(shadow.view_h) << bmi_pkg::FRAC_BITS);
            b.vel_x       = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            b.vel_y       = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            b.push_x      = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            b.push_y      = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            b.ball_radius = $urandom_range(0, 32'h0040_0000);
        end
        else
        begin
            b.pos_x       = rand_word();
            b.pos_y       = rand_word();
            b.vel_x       = rand_word();
            b.vel_y       = rand_word();
            b.push_x      = rand_word();
            b.push_y      = rand_word();
            b.ball_radius = $urandom_range(3) == 0 ? 31'h7fff_ffff : 31'($urandom);
        end
        return b;
    endfunction

    task automatic wait_drained();
        while (pending_balls.size() > 0 || expected_motion.size() > 0)
            @(posedge clk);
        repeat (SETTLE_LIMIT) @(posedge clk);
    endtask

    // One write; valid drops before the task returns, so back-to-back writes never overlap
    task automatic write_reg(input bmi_pkg::cfg_idx_e idx, input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            bmi_pkg::REG_PUSH_GAIN:    shadow.push_gain    = value;
            bmi_pkg::REG_MOVE_GAIN:    shadow.move_gain    = value;
            bmi_pkg::REG_GRAVITY_STEP: shadow.gravity_step = value;
            bmi_pkg::REG_BOUNCE_GAIN:  shadow.bounce_gain  = value[16:0];
            bmi_pkg::REG_WALL_BOUNCE:  shadow.wall_bounce  = value[0];
            bmi_pkg::REG_VIEW_W:       shadow.view_w       = value[14:0];
            bmi_pkg::REG_VIEW_H:       shadow.view_h       = value[14:0];
            default: ;
        endcase
    endtask

    task automatic ball(input logic [31:0] px, py, vx, vy, hx, hy,
                        input logic [30:0] r);
        bmi_pkg::item_t b;
        b = '{px, py, vx, vy, hx, hy, r};
        pending_balls.push_back(b);
    endtask

    task automatic random_phase(input int n);
        repeat (n) pending_balls.push_back(rand_ball());
        wait_drained();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.vel_x = '0; in_ch.vel_y = '0;
        in_ch.push_x = '0; in_ch.push_y = '0; in_ch.ball_radius = '0;
        cfg.valid = 1'b0; cfg.index = bmi_pkg::REG_PUSH_GAIN; cfg.data = '0;
        shadow = '{bmi_pkg::PUSH_GAIN_RST, bmi_pkg::MOVE_GAIN_RST, 32'sd0,
                   bmi_pkg::BOUNCE_GAIN_RST, 1'b1,
                   bmi_pkg::VIEW_W_RST, bmi_pkg::VIEW_H_RST};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, edge hits, field extremes, saturation
        ball(32'h0010_0000, 32'h0010_0000, 32'h0001_0000, 32'hffff_0000,
             32'h0, 32'h0, 31'h0008_0000);
        ball(32'h0, 32'h0, 32'hfff0_0000, 32'hfff0_0000, 32'h0, 32'h0, 31'h0010_0000);
        ball(32'h0400_0000, 32'h0300_0000, 32'h0010_0000, 32'h0010_0000,
             32'h0, 32'h0, 31'h0010_0000);
        ball(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h7fff_ffff);
        ball(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
             32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        ball(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, 32'h7fff_ffff, 31'h0);
        ball(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
        // wider than the screen: ends at width minus radius
        ball(32'h0200_0000, 32'h0100_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0,
             31'h0300_0000);
        wait_drained();

        // Edges off: strict out-of-bounds comparisons and gravity
        write_reg(bmi_pkg::REG_WALL_BOUNCE, 32'd0);
        write_reg(bmi_pkg::REG_GRAVITY_STEP, 32'h0000_8000);
        ball(32'hfff0_0000, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0010_0000);
        ball(32'hffef_ffff, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0010_0000);
        ball(32'h0410_0000, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0010_0000);
        ball(32'h0410_0001, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0010_0000);
        ball(32'h0010_0000, 32'h0310_0001, 32'h0, 32'hffff_8000, 32'h0, 32'h0,
             31'h0010_0000);
        ball(32'h0010_0000, 32'hffef_ffff, 32'h0, 32'hffff_8000, 32'h0, 32'h0,
             31'h0010_0000);
        wait_drained();
        random_phase(150);

        // Extreme gains, bounce above one, one-pixel screen
        write_reg(bmi_pkg::REG_WALL_BOUNCE, 32'd1);
        write_reg(bmi_pkg::REG_PUSH_GAIN, 32'hffff_ffff);
        write_reg(bmi_pkg::REG_MOVE_GAIN, 32'hffff_ffff);
        write_reg(bmi_pkg::REG_BOUNCE_GAIN, 32'h0001_ffff);
        write_reg(bmi_pkg::REG_VIEW_W, 32'd1);
        write_reg(bmi_pkg::REG_VIEW_H, 32'd1);
        write_reg(bmi_pkg::REG_GRAVITY_STEP, 32'h8000_0000);
        random_phase(200);

        write_reg(bmi_pkg::REG_PUSH_GAIN, 32'd0);
        write_reg(bmi_pkg::REG_MOVE_GAIN, 32'd0);
        write_reg(bmi_pkg::REG_BOUNCE_GAIN, 32'd0);
        write_reg(bmi_pkg::REG_GRAVITY_STEP, 32'h7fff_ffff);
        write_reg(bmi_pkg::REG_VIEW_W, 32'd0);
        write_reg(bmi_pkg::REG_VIEW_H, 32'd0);
        random_phase(150);

        write_reg(bmi_pkg::REG_PUSH_GAIN, 32'h0004_0000);
        write_reg(bmi_pkg::REG_MOVE_GAIN, 32'h0000_0400);
        write_reg(bmi_pkg::REG_BOUNCE_GAIN, 32'h0001_0000);
        write_reg(bmi_pkg::REG_GRAVITY_STEP, 32'h0000_0106);
        write_reg(bmi_pkg::REG_VIEW_W, 32'd32767);
        write_reg(bmi_pkg::REG_VIEW_H, 32'd32767);
        random_phase(250);

        // Long receiver hold-off while balls keep coming, so the pipe backs up
        sink_hold = 1'b1;
        repeat (60) pending_balls.push_back(rand_ball());
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        wait_drained();

        // Stretch with no idling on either side
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        write_reg(bmi_pkg::REG_VIEW_W, 32'd640);
        write_reg(bmi_pkg::REG_VIEW_H, 32'd480);
        write_reg(bmi_pkg::REG_MOVE_GAIN, 32'h0001_0000);
        random_phase(300);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;

        write_reg(bmi_pkg::REG_WALL_BOUNCE, 32'd0);
        write_reg(bmi_pkg::REG_BOUNCE_GAIN, 32'h0000_c000);
        random_phase(350);
        write_reg(bmi_pkg::REG_WALL_BOUNCE, 32'd1);
        write_reg(bmi_pkg::REG_PUSH_GAIN, 32'h0001_0000);
        write_reg(bmi_pkg::REG_GRAVITY_STEP, 32'hffff_f000);
        random_phase(350);

        $display("run: %0d balls integrated across several register settings,",
                 balls_sent);
        $display("     %0d results checked, %0d flagged out of bounds", results_seen,
                 oob_hits);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
